/* hw/rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Types, character codes and character-class decoders shared by the token
// splitter modules.
// ----------------------------------------------------------------------------
package sts_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_WORD    = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_OP1     = 3'd4,
    MODE_OP2     = 3'd5
  } lex_mode_t;

  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_STRING = 2'd1;
  localparam logic [1:0] KIND_OPER   = 2'd2;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic [1:0] tok_kind;
    logic       tok_last;
  } tok_beat_t;

  // beats of one input item, beat[0] goes out first
  typedef struct packed {
    logic [1:0]      count;
    tok_beat_t [2:0] beat;
  } step_out_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
  endfunction

  // operators that take a trailing '='
  function automatic logic is_eq_op(input logic [7:0] c);
    return c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h21, 8'h3E, 8'h3C,
                     8'h26, 8'h7C, 8'h5E};
  endfunction

  // operators that may be doubled
  function automatic logic is_dbl_op(input logic [7:0] c);
    return c inside {8'h2B, 8'h2D, 8'h3D, 8'h3E, 8'h3C, 8'h26, 8'h7C};
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3D, 8'h21, 8'h3E,
                     8'h3C, 8'h26, 8'h7C, 8'h5E, 8'h7E, 8'h2E, 8'h7B, 8'h5B,
                     8'h28, 8'h2C};
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return is_space(c) || is_oper(c) ||
           (c inside {8'h7D, 8'h5D, 8'h29, 8'h22, 8'h27});
  endfunction

endpackage

/* hw/rtl/sts_in_if.sv */
// ----------------------------------------------------------------------------
// sts_in_if
// Source byte channel: valid/ready handshake with one source byte per beat.
// ----------------------------------------------------------------------------
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

/* hw/rtl/sts_tok_if.sv */
// ----------------------------------------------------------------------------
// sts_tok_if
// Token channel: valid/ready handshake with one token byte per beat.
// ----------------------------------------------------------------------------
interface sts_tok_if;
  logic       valid;
  logic       ready;
  logic [7:0] tok_byte;
  logic [1:0] tok_kind;
  logic       tok_last;

  modport source (output valid, output tok_byte, output tok_kind, output tok_last,
                  input ready);
  modport sink   (input valid, input tok_byte, input tok_kind, input tok_last,
                  output ready);
endinterface

/* hw/rtl/sts_lexer.sv */
// ----------------------------------------------------------------------------
// sts_lexer
// Lexer state and single-pass next-state logic. Produces up to three token
// beats for each accepted source byte and advances its state on accept.
// ----------------------------------------------------------------------------
module sts_lexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               end_of_input,
  output sts_pkg::step_out_t step
);

  sts_pkg::lex_mode_t lex_mode, lex_mode_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic [1:0] held_kind, held_kind_next;
  logic [7:0] quote_char, quote_char_next;
  logic [7:0] prev_string_byte, prev_string_byte_next;
  logic [7:0] op_first, op_first_next;
  logic [7:0] op_second, op_second_next;

  // token-start decode of the incoming byte
  sts_pkg::lex_mode_t st_mode;
  logic       st_hold;
  logic [1:0] st_kind;
  logic       st_string;
  logic       st_op;
  logic       do_start;
  logic       op_match;

  always_comb begin
    st_mode   = sts_pkg::MODE_WORD;
    st_hold   = 1'b1;
    st_kind   = sts_pkg::KIND_WORD;
    st_string = 1'b0;
    st_op     = 1'b0;
    if (sts_pkg::is_space(in_byte)) begin
      st_mode = sts_pkg::MODE_IDLE;
      st_hold = 1'b0;
    end else if (in_byte == sts_pkg::CH_HASH) begin
      st_mode = sts_pkg::MODE_COMMENT;
      st_hold = 1'b0;
    end else if (in_byte == sts_pkg::CH_SQUOTE || in_byte == sts_pkg::CH_DQUOTE) begin
      st_mode   = sts_pkg::MODE_STRING;
      st_kind   = sts_pkg::KIND_STRING;
      st_string = 1'b1;
    end else if (sts_pkg::is_oper(in_byte)) begin
      st_mode = sts_pkg::MODE_OP1;
      st_hold = 1'b0;
      st_op   = 1'b1;
    end
  end

  assign op_match = (in_byte == sts_pkg::CH_EQ && sts_pkg::is_eq_op(op_first)) ||
                    (in_byte == op_first && sts_pkg::is_dbl_op(op_first));

  always_comb begin
    lex_mode_next         = lex_mode;
    held_byte_next        = held_byte;
    held_valid_next       = held_valid;
    held_kind_next        = held_kind;
    quote_char_next       = quote_char;
    prev_string_byte_next = prev_string_byte;
    op_first_next         = op_first;
    op_second_next        = op_second;
    do_start              = 1'b0;
    step                  = '0;

    if (end_of_input) begin
      case (lex_mode)
        sts_pkg::MODE_WORD, sts_pkg::MODE_STRING: begin
          if (held_valid) begin
            step.beat[0] = '{held_byte, held_kind, 1'b1};
            step.count   = 2'd1;
          end
        end
        sts_pkg::MODE_OP1: begin
          step.beat[0] = '{op_first, sts_pkg::KIND_OPER, 1'b1};
          step.count   = 2'd1;
        end
        sts_pkg::MODE_OP2: begin
          step.beat[0] = '{op_first, sts_pkg::KIND_OPER, 1'b0};
          step.beat[1] = '{op_second, sts_pkg::KIND_OPER, 1'b1};
          step.count   = 2'd2;
        end
        default: ;
      endcase
      held_valid_next = 1'b0;
      lex_mode_next   = sts_pkg::MODE_IDLE;
    end else begin
      case (lex_mode)
        sts_pkg::MODE_COMMENT: begin
          if (in_byte == sts_pkg::CH_NL) lex_mode_next = sts_pkg::MODE_IDLE;
        end
        sts_pkg::MODE_WORD: begin
          if (sts_pkg::is_delim(in_byte)) begin
            if (held_valid) begin
              step.beat[0] = '{held_byte, held_kind, 1'b1};
              step.count   = 2'd1;
            end
            held_valid_next = 1'b0;
            do_start        = 1'b1;
          end else begin
            step.beat[0]    = '{held_byte, held_kind, 1'b0};
            step.count      = 2'd1;
            held_byte_next  = in_byte;
            held_kind_next  = sts_pkg::KIND_WORD;
            held_valid_next = 1'b1;
          end
        end
        sts_pkg::MODE_STRING: begin
          // close only on a matching quote not preceded by a backslash
          if (in_byte == quote_char && prev_string_byte != sts_pkg::CH_BSLASH) begin
            if (held_valid) begin
              step.beat[0] = '{held_byte, held_kind, 1'b1};
              step.count   = 2'd1;
            end
            held_valid_next = 1'b0;
            lex_mode_next   = sts_pkg::MODE_IDLE;
          end else begin
            step.beat[0]          = '{held_byte, held_kind, 1'b0};
            step.count            = 2'd1;
            held_byte_next        = in_byte;
            held_kind_next        = sts_pkg::KIND_STRING;
            held_valid_next       = 1'b1;
            prev_string_byte_next = in_byte;
          end
        end
        sts_pkg::MODE_OP1: begin
          if (op_match) begin
            if ((op_first == sts_pkg::CH_LT || op_first == sts_pkg::CH_GT) &&
                in_byte == op_first) begin
              // hold << or >> until the next byte decides on a trailing '='
              op_second_next = in_byte;
              lex_mode_next  = sts_pkg::MODE_OP2;
            end else begin
              step.beat[0]  = '{op_first, sts_pkg::KIND_OPER, 1'b0};
              step.beat[1]  = '{in_byte, sts_pkg::KIND_OPER, 1'b1};
              step.count    = 2'd2;
              lex_mode_next = sts_pkg::MODE_IDLE;
            end
          end else begin
            step.beat[0] = '{op_first, sts_pkg::KIND_OPER, 1'b1};
            step.count   = 2'd1;
            do_start     = 1'b1;
          end
        end
        sts_pkg::MODE_OP2: begin
          step.beat[0] = '{op_first, sts_pkg::KIND_OPER, 1'b0};
          if (in_byte == sts_pkg::CH_EQ) begin
            step.beat[1]  = '{op_second, sts_pkg::KIND_OPER, 1'b0};
            step.beat[2]  = '{in_byte, sts_pkg::KIND_OPER, 1'b1};
            step.count    = 2'd3;
            lex_mode_next = sts_pkg::MODE_IDLE;
          end else begin
            step.beat[1] = '{op_second, sts_pkg::KIND_OPER, 1'b1};
            step.count   = 2'd2;
            do_start     = 1'b1;
          end
        end
        default: begin
          held_valid_next = 1'b0;
          do_start        = 1'b1;
        end
      endcase

      if (do_start) begin
        lex_mode_next = st_mode;
        if (st_hold) begin
          held_byte_next  = in_byte;
          held_kind_next  = st_kind;
          held_valid_next = 1'b1;
        end
        if (st_string) begin
          quote_char_next       = in_byte;
          prev_string_byte_next = 8'h00;
        end
        if (st_op) op_first_next = in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode         <= sts_pkg::MODE_IDLE;
      held_byte        <= 8'h00;
      held_valid       <= 1'b0;
      held_kind        <= sts_pkg::KIND_WORD;
      quote_char       <= 8'h00;
      prev_string_byte <= 8'h00;
      op_first         <= 8'h00;
      op_second        <= 8'h00;
    end else if (accept) begin
      lex_mode         <= lex_mode_next;
      held_byte        <= held_byte_next;
      held_valid       <= held_valid_next;
      held_kind        <= held_kind_next;
      quote_char       <= quote_char_next;
      prev_string_byte <= prev_string_byte_next;
      op_first         <= op_first_next;
      op_second        <= op_second_next;
    end
  end

  a_op2_angle : assert property (@(posedge clk) disable iff (rst)
    lex_mode == sts_pkg::MODE_OP2 |->
      (op_first == sts_pkg::CH_LT || op_first == sts_pkg::CH_GT) &&
      op_second == op_first)
    else $error("doubled-operator mode without a held << or >>");

  a_word_held : assert property (@(posedge clk) disable iff (rst)
    (lex_mode == sts_pkg::MODE_WORD || lex_mode == sts_pkg::MODE_STRING) |-> held_valid)
    else $error("word or string mode without a held byte");

  a_idle_nothing : assert property (@(posedge clk) disable iff (rst)
    (lex_mode == sts_pkg::MODE_IDLE || lex_mode == sts_pkg::MODE_COMMENT) |->
      step.count == 2'd0)
    else $error("idle or comment mode produced token beats");

endmodule

/* hw/rtl/sts_out_buf.sv */
// ----------------------------------------------------------------------------
// sts_out_buf
// Result register: holds one source byte's beats, sends one per cycle while
// tok.ready is high. Loads anew once at most one beat is left and leaving.
// ----------------------------------------------------------------------------
module sts_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  sts_pkg::step_out_t step,
  output logic               can_load,
  sts_tok_if.source          tok
);

  logic [1:0]               cnt;
  sts_pkg::tok_beat_t [2:0] q;
  logic                     pop;

  assign tok.valid    = (cnt != 2'd0);
  assign tok.tok_byte = q[0].tok_byte;
  assign tok.tok_kind = q[0].tok_kind;
  assign tok.tok_last = q[0].tok_last;
  assign pop          = tok.valid && tok.ready;
  assign can_load     = !rst && (cnt == 2'd0 || (cnt == 2'd1 && tok.ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= step.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // advance the queue by one beat on each pop
  always_ff @(posedge clk) begin
    if (load) begin
      q <= step.beat;
    end else if (pop) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

  a_load_count : assert property (@(posedge clk) disable iff (rst)
    load |=> cnt == $past(step.count))
    else $error("beat count does not follow the loaded item");

  a_pop_count : assert property (@(posedge clk) disable iff (rst)
    pop && !load |=> cnt == $past(cnt) - 2'd1)
    else $error("beat count did not drop after a pop");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    load |-> cnt == 2'd0 || (cnt == 2'd1 && pop))
    else $error("load while beats are still pending");

endmodule

/* hw/rtl/source_token_splitter.sv */
// ----------------------------------------------------------------------------
// source_token_splitter
// Splits a source byte stream into word, string and operator tokens, sent
// one byte per beat with a kind and a last flag.
// ----------------------------------------------------------------------------
// Output: the first token beat caused by a source byte is registered and
//   valid in the cycle after that byte is accepted.
// Throughput: one source byte per cycle while each byte yields at most one
//   beat and tok.ready is high; a byte with more beats (up to three, on
//   operator flushes) holds the single result register and its output port.
// Reset: synchronous rst returns the lexer to idle between tokens, drops
//   any pending beats, and holds src.ready low while asserted.
module source_token_splitter (
  input  logic     clk,
  input  logic     rst,
  sts_in_if.sink   src,
  sts_tok_if.source tok
);

  sts_pkg::step_out_t step;
  logic               can_load;
  logic               accept;

  assign src.ready = can_load;
  assign accept    = src.valid && can_load;

  sts_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (src.in_byte),
    .end_of_input (src.end_of_input),
    .step         (step)
  );

  sts_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .step     (step),
    .can_load (can_load),
    .tok      (tok)
  );

endmodule
